[rtl/assert_macros.svh]
// Assertion macros shared by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/dmht_pkg.sv]
// Package with the field widths, codes and state type of the deadline heap timer.
`timescale 1ns / 1ps
package dmht_pkg;

  localparam int TIME_BITS         = 64;
  localparam int HANDLE_FIELD_BITS = 16;
  localparam int OCC_BITS          = 8;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FIRED    = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_TICK   = 1'b1
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_UP_CMP,
    S_UP_PUT,
    S_TK_RD,
    S_TK_CHK,
    S_DN_CMP,
    S_DN_PUT,
    S_DONE
  } fsm_t;

endpackage

[rtl/dmht_req_if.sv]
// Request channel of the deadline heap timer: operation, time and handle.
`timescale 1ns / 1ps
interface dmht_req_if;
  import dmht_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [TIME_BITS-1:0]         time_value;
  logic [HANDLE_FIELD_BITS-1:0] entry_handle;

  modport source(output valid, mode, time_value, entry_handle, input ready);
  modport sink(input valid, mode, time_value, entry_handle, output ready);
endinterface

[rtl/dmht_rsp_if.sv]
// Response channel of the deadline heap timer: status, fired entry and occupancy.
`timescale 1ns / 1ps
interface dmht_rsp_if;
  import dmht_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [HANDLE_FIELD_BITS-1:0] fired_handle;
  logic [TIME_BITS-1:0]         fired_deadline;
  logic [OCC_BITS-1:0]          occupancy;

  modport source(output valid, status, fired_handle, fired_deadline, occupancy,
                 input ready);
  modport sink(input valid, status, fired_handle, fired_deadline, occupancy,
               output ready);
endinterface

[rtl/deadline_min_heap_timer_unit.sv]
// Top level of the deadline heap timer: a binary min-heap of timers in one memory.
`timescale 1ns / 1ps
// Usage. Requests arrive on req: mode 0 inserts (time_value as deadline, entry_handle
// as payload), mode 1 is a tick carrying the current time. Every request produces
// exactly one transfer on rsp with a status, the fired entry (zero unless fired)
// and the number of pending entries after the request.
// Operation. The heap lives in one memory with one write port and two registered read
// ports, and the engine works on one heap level at a time. An insert puts the new entry
// in the first free position and lets it rise while its parent's deadline is later; an
// insert into an empty or a full heap goes straight to its result. A tick that fires
// and leaves two or more entries moves the last entry to the root and lets it sink;
// a tick that finds nothing due or leaves fewer than two entries ends after the root
// check, and a tick on an empty heap ends before it. One request is worked on at a
// time; req.ready is high only while the engine idles, so the next request is taken
// only after the last result has gone into the output register.
// Stalls. The result sits in an output register; when rsp is stalled the engine
// holds its finished result until the register frees, and keeps req.ready low.
// Reset. rst clears the entry count and the control state. The memory is not
// cleared: only positions up to the count are ever used.
module deadline_min_heap_timer_unit #(
  parameter int CAPACITY    = 255,
  parameter int HANDLE_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  dmht_req_if.sink  req,
  dmht_rsp_if.source rsp
);
  import dmht_pkg::*;

  `include "assert_macros.svh"

  // Stored handle width: the request field never carries more than its own bits.
  localparam int HW = (HANDLE_BITS < HANDLE_FIELD_BITS) ? HANDLE_BITS : HANDLE_FIELD_BITS;
  localparam int WW = TIME_BITS + HW;
  // Heap positions run 1..CAPACITY; position 0 of the memory is unused.
  localparam int AW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] CAP_W = AW'(CAPACITY);
  localparam logic [AW-1:0] ONE_W = AW'(1);

  fsm_t state, state_next;

  // Heap memory, one word per entry: deadline above handle.
  logic [WW-1:0] mem [CAPACITY+1];
  logic [WW-1:0] rd_a, rd_b;
  logic [AW-1:0] ra, rb, wa;
  logic [WW-1:0] wd;
  logic          we;

  // Request under work and engine registers.
  logic [TIME_BITS-1:0] tv_q;
  logic [HW-1:0]        hd_q;
  logic [AW-1:0]        cnt;
  logic [AW-1:0]        pos;
  logic [WW-1:0]        last_word;
  status_t              res_st;
  logic [WW-1:0]        res_word;

  // Output register.
  logic                         out_valid;
  status_t                      out_st;
  logic [HANDLE_FIELD_BITS-1:0] out_hd;
  logic [TIME_BITS-1:0]         out_dl;
  logic [OCC_BITS-1:0]          out_occ;

  logic [WW-1:0]        new_word;
  logic [TIME_BITS-1:0] rd_a_dl, rd_b_dl, last_dl;
  logic [AW-1:0]        cnt_inc, cnt_dec;
  logic                 up_move;
  logic                 due;
  logic                 out_free;

  // Sift-down child selection.
  logic [AW:0]          kid_l, kid_r, n_w;
  logic                 right_ok, pick_right, dn_move;
  logic [AW-1:0]        kid_c;
  logic [WW-1:0]        chosen;
  logic [AW:0]          next_l, next_r;
  logic                 next_kids;
  // Children of the root while the tick is being checked.
  logic [AW:0]          root_n;
  logic                 root_kids, root_right;

  assign new_word = {tv_q, hd_q};
  assign rd_a_dl  = rd_a[WW-1 -: TIME_BITS];
  assign rd_b_dl  = rd_b[WW-1 -: TIME_BITS];
  assign last_dl  = last_word[WW-1 -: TIME_BITS];
  assign cnt_inc  = cnt + ONE_W;
  assign cnt_dec  = cnt - ONE_W;
  assign up_move  = rd_a_dl > tv_q;
  assign due      = !(rd_a_dl > tv_q);
  assign out_free = !out_valid || rsp.ready;

  // Port A holds the left child, port B the right child when one exists.
  assign n_w        = {1'b0, cnt};
  assign kid_l      = {pos, 1'b0};
  assign kid_r      = kid_l + 1'b1;
  assign right_ok   = kid_r <= n_w;
  assign pick_right = right_ok && (rd_b_dl < rd_a_dl);
  assign kid_c      = pick_right ? kid_r[AW-1:0] : kid_l[AW-1:0];
  assign chosen     = pick_right ? rd_b : rd_a;
  assign dn_move    = chosen[WW-1 -: TIME_BITS] < last_dl;
  assign next_l     = {kid_c, 1'b0};
  assign next_r     = next_l + 1'b1;
  assign next_kids  = next_l <= n_w;

  assign root_n     = {1'b0, cnt_dec};
  assign root_kids  = (AW+1)'(2) <= root_n;
  assign root_right = (AW+1)'(3) <= root_n;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (mode_t'(req.mode) == MODE_TICK) ? S_TK_RD : S_INS;
        end
      end
      S_INS: begin
        if (cnt >= CAP_W || cnt == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (!up_move) begin
          state_next = S_DONE;
        end else if ((pos >> 1) == ONE_W) begin
          state_next = S_UP_PUT;
        end
      end
      S_UP_PUT: state_next = S_DONE;
      S_TK_RD: state_next = (cnt == '0) ? S_DONE : S_TK_CHK;
      S_TK_CHK: state_next = (due && root_kids) ? S_DN_CMP : S_DONE;
      S_DN_CMP: begin
        if (!dn_move) begin
          state_next = S_DONE;
        end else if (!next_kids) begin
          state_next = S_DN_PUT;
        end
      end
      S_DN_PUT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    ra = ONE_W;
    rb = ONE_W;
    we = 1'b0;
    wa = ONE_W;
    wd = new_word;
    case (state)
      S_INS: begin
        ra = cnt_inc >> 1;
        if (cnt == '0) begin
          we = 1'b1;
          wa = ONE_W;
        end
      end
      S_UP_CMP: begin
        ra = pos >> 2;
        we = 1'b1;
        wa = pos;
        wd = up_move ? rd_a : new_word;
      end
      S_UP_PUT: begin
        we = 1'b1;
        wa = pos;
      end
      S_TK_RD: begin
        ra = ONE_W;
        rb = cnt;
      end
      S_TK_CHK: begin
        ra = AW'(2);
        rb = root_right ? AW'(3) : AW'(2);
        // With a single entry left it moves straight to the root.
        if (due && !root_kids && cnt_dec != '0) begin
          we = 1'b1;
          wa = ONE_W;
          wd = rd_b;
        end
      end
      S_DN_CMP: begin
        ra = next_l[AW-1:0];
        rb = (next_r <= n_w) ? next_r[AW-1:0] : next_l[AW-1:0];
        we = 1'b1;
        wa = pos;
        wd = dn_move ? chosen : last_word;
      end
      S_DN_PUT: begin
        we = 1'b1;
        wa = pos;
        wd = last_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INS && cnt < CAP_W) begin
        cnt <= cnt_inc;
      end
      if (state == S_TK_CHK && due) begin
        cnt <= cnt_dec;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          tv_q   <= req.time_value;
          hd_q   <= HW'(req.entry_handle);
        end
      end
      S_INS: begin
        pos      <= cnt_inc;
        res_word <= '0;
        res_st   <= (cnt >= CAP_W) ? ST_FULL : ST_INSERTED;
      end
      S_UP_CMP: begin
        if (up_move) begin
          pos <= pos >> 1;
        end
      end
      S_TK_RD: begin
        res_word <= '0;
        res_st   <= ST_NONE;
      end
      S_TK_CHK: begin
        pos       <= ONE_W;
        last_word <= rd_b;
        if (due) begin
          res_word <= rd_a;
          res_st   <= ST_FIRED;
        end
      end
      S_DN_CMP: begin
        if (dn_move) begin
          pos <= kid_c;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_st  <= res_st;
          out_hd  <= HANDLE_FIELD_BITS'(res_word[HW-1:0]);
          out_dl  <= res_word[WW-1 -: TIME_BITS];
          out_occ <= OCC_BITS'(cnt);
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_st;
  assign rsp.fired_handle   = out_hd;
  assign rsp.fired_deadline = out_dl;
  assign rsp.occupancy      = out_occ;

  // Writes stay inside the live heap, or hit the slot that an insert is adding,
  // and finish before the next request.
  `ASSERT_NEVER(a_write_in_heap, clk, rst, we && (wa == '0 || (AW+1)'(wa) > n_w + 1'b1), "heap write outside the live entries")
  `ASSERT_NEVER(a_quiet_when_ready, clk, rst, req.ready && we, "memory write while a request can be taken")
  `ASSERT_NEVER(a_count_range, clk, rst, cnt > CAP_W, "entry count above capacity")
  `ASSERT_AT(a_count_step, clk, rst, (cnt == $past(cnt)) || (cnt == $past(cnt) + ONE_W) || (cnt == $past(cnt) - ONE_W), "entry count moved by more than one")

endmodule
